// ----- src/sctl_pkg.sv -----
// Shared constants and types for the stretched colour table lookup core.
`timescale 1ns / 1ps

package sctl_pkg;

   // Table size default and field widths
   localparam int TABLE_ENTRIES_DEFAULT = 256;
   localparam int POS_W      = 16;
   localparam int OFFSET_W   = 21;
   localparam int GAIN_W     = 32;
   localparam int DIFF_W     = 22;
   localparam int MAG_W      = 21;
   localparam int COLOUR_W   = 16;
   localparam int EIDX_W     = 8;
   localparam int IDX_OUT_W  = 8;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Operation codes carried in tuser
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_WRITE  = 1'b1;

   // Register indexes (byte address bits [3:2])
   localparam logic [1:0] REG_ZERO_OFFSET = 2'd0;
   localparam logic [1:0] REG_INDEX_GAIN  = 2'd1;
   localparam logic [1:0] REG_ENDS_MODE   = 2'd2;
   localparam logic [1:0] REG_FLIP_ENDS   = 2'd3;

   // End handling modes
   typedef enum logic [1:0] {
      ENDS_BLACK_WHITE = 2'd0,
      ENDS_WHITE_BLACK = 2'd1,
      ENDS_TABLE       = 2'd2,
      ENDS_WRAP        = 2'd3
   } ends_mode_type;

   // Register reset values
   localparam logic [OFFSET_W-1:0] ZERO_OFFSET_RESET = '0;
   localparam logic [GAIN_W-1:0]   INDEX_GAIN_RESET  = 32'h00FF_0000;
   localparam ends_mode_type       ENDS_MODE_RESET   = ENDS_BLACK_WHITE;
   localparam logic                FLIP_ENDS_RESET   = 1'b0;

endpackage

// ----- src/stretched_colour_table_lookup_core.sv -----
// Stretched colour table lookup: pipelined index stretch, end handling and RGB table.
//
//   channel | direction | tdata (low bit up)                            | tuser
//   req_    | in        | position, entry_index, red, green, blue       | opcode
//   rsp_    | out       | red, green, blue, table_index                 | -
//   csr_    | in/out    | zero_offset, index_gain, ends_mode, flip_ends | -
//
// One word is taken per clock while rsp_tready does not stall the pipeline.
// Seven register stages: input register, offset subtract, gain multiply, reciprocal
// multiply for the wrap residue, residue and range flags, table read, output register.
// Each stage moves when the next is empty or moving, so bubbles close up under stall.
// Writes update the table in the same stage that lookups read it, keeping word order.
// Reset (synchronous, active high) clears the pipeline and the registers; the table
// holds garbage until written.
`timescale 1ns / 1ps

module stretched_colour_table_lookup_core #(
   parameter int TABLE_ENTRIES = sctl_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // position, entry_index, entry_red, entry_green, entry_blue
   input  logic [sctl_pkg::REQ_DATA_W-1:0]     req_tdata,
   // opcode
   input  logic                                req_tuser,
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // red, green, blue, table_index
   output logic [sctl_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sctl_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sctl_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sctl_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int IDX_W       = $clog2(TABLE_ENTRIES);
   localparam int RES_W       = IDX_W + 1;
   localparam int CMP_W       = (IDX_W + 1 > 9) ? IDX_W + 1 : 9;
   localparam int RECIP_SHIFT = sctl_pkg::MAG_W + IDX_W;
   localparam int RECIP_W     = 23;
   localparam int QPROD_W     = sctl_pkg::MAG_W + RECIP_W;
   localparam int GPROD_W     = sctl_pkg::MAG_W + sctl_pkg::GAIN_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((64'd1 << RECIP_SHIFT) / TABLE_ENTRIES);
   localparam logic [RES_W-1:0] N_RES   = RES_W'(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(TABLE_ENTRIES - 1);
   localparam int COL3_W = 3 * sctl_pkg::COLOUR_W;

   // configuration registers
   logic [sctl_pkg::OFFSET_W-1:0] zero_offset_ff;
   logic [sctl_pkg::GAIN_W-1:0]   index_gain_ff;
   sctl_pkg::ends_mode_type       ends_mode_ff;
   logic                          flip_ends_ff;
   logic                          csr_wr;

   // stage handshake
   logic [5:0] valid_ff;
   logic [6:0] ld;
   logic       rsp_valid_ff;

   // stage 0: input word
   logic                         s0_op_ff;
   logic [sctl_pkg::POS_W-1:0]   s0_pos_ff;
   logic [sctl_pkg::EIDX_W-1:0]  s0_eidx_ff;
   logic [COL3_W-1:0]            s0_col_ff;
   // stage 1: magnitude of offset difference
   logic [sctl_pkg::DIFF_W-1:0]  diff;
   logic [sctl_pkg::MAG_W-1:0]   mag_in;
   logic                         s1_op_ff, s1_neg_ff;
   logic [sctl_pkg::MAG_W-1:0]   s1_mag_ff;
   logic [sctl_pkg::EIDX_W-1:0]  s1_eidx_ff;
   logic [COL3_W-1:0]            s1_col_ff;
   // stage 2: stretched magnitude
   logic [GPROD_W-1:0]           gprod;
   logic                         s2_op_ff, s2_neg_ff;
   logic [sctl_pkg::MAG_W-1:0]   s2_prod_ff;
   logic [sctl_pkg::EIDX_W-1:0]  s2_eidx_ff;
   logic [COL3_W-1:0]            s2_col_ff;
   // stage 3: estimated quotient by table size
   logic [QPROD_W-1:0]           qprod;
   logic                         s3_op_ff, s3_neg_ff;
   logic [sctl_pkg::MAG_W-1:0]   s3_prod_ff, s3_quot_ff;
   logic [sctl_pkg::EIDX_W-1:0]  s3_eidx_ff;
   logic [COL3_W-1:0]            s3_col_ff;
   // stage 4: residue and range flags
   logic [sctl_pkg::MAG_W-1:0]   qn, resid_full;
   logic                         s4_op_ff, s4_neg_ff, s4_below_ff, s4_above_ff;
   logic [RES_W-1:0]             s4_resid_ff;
   logic [IDX_W-1:0]             s4_idx_ff;
   logic [sctl_pkg::EIDX_W-1:0]  s4_eidx_ff;
   logic [COL3_W-1:0]            s4_col_ff;
   // stage 5: final index and table read
   logic [RES_W-1:0]             res_a, res_b;
   logic                         lo_white, tbl_we;
   logic [IDX_W-1:0]             s5_idx_in;
   logic                         s5_level_in, s5_white_in;
   logic [IDX_W-1:0]             s5_idx_ff;
   logic                         s5_level_ff, s5_white_ff;
   logic [COL3_W-1:0]            mem_rd_ff;
   logic [COL3_W-1:0]            table_mem [TABLE_ENTRIES];
   // output word
   logic [COL3_W-1:0]            rsp_col_in;
   logic [sctl_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // register port: always ready, decoded on word address
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_offset_ff <= sctl_pkg::ZERO_OFFSET_RESET;
         index_gain_ff  <= sctl_pkg::INDEX_GAIN_RESET;
         ends_mode_ff   <= sctl_pkg::ENDS_MODE_RESET;
         flip_ends_ff   <= sctl_pkg::FLIP_ENDS_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            sctl_pkg::REG_ZERO_OFFSET: zero_offset_ff <= csr_pwdata[sctl_pkg::OFFSET_W-1:0];
            sctl_pkg::REG_INDEX_GAIN:  index_gain_ff  <= csr_pwdata;
            sctl_pkg::REG_ENDS_MODE:   ends_mode_ff   <= sctl_pkg::ends_mode_type'(csr_pwdata[1:0]);
            sctl_pkg::REG_FLIP_ENDS:   flip_ends_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         sctl_pkg::REG_ZERO_OFFSET:
            csr_prdata = {{(sctl_pkg::CSR_DATA_W - sctl_pkg::OFFSET_W){zero_offset_ff[20]}},
                          zero_offset_ff};
         sctl_pkg::REG_INDEX_GAIN: csr_prdata = index_gain_ff;
         sctl_pkg::REG_ENDS_MODE:  csr_prdata = {30'd0, ends_mode_ff};
         sctl_pkg::REG_FLIP_ENDS:  csr_prdata = {31'd0, flip_ends_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   // load enables: a stage loads when empty or when its successor loads
   always_comb begin
      ld[6] = !rsp_valid_ff || rsp_tready;
      for (int k = 5; k >= 0; k--) begin
         ld[k] = !valid_ff[k] || ld[k+1];
      end
   end

   assign req_tready = ld[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ld[0]) valid_ff[0] <= req_tvalid;
         for (int k = 1; k < 5; k++) begin
            if (ld[k]) valid_ff[k] <= valid_ff[k-1];
         end
         // writes end at the table; only lookups go on
         if (ld[5]) valid_ff[5] <= valid_ff[4] && (s4_op_ff == sctl_pkg::OP_LOOKUP);
         if (ld[6]) rsp_valid_ff <= valid_ff[5];
      end
   end

   // stage 0: capture word
   always_ff @(posedge clock) begin
      if (ld[0]) begin
         s0_op_ff   <= req_tuser;
         s0_pos_ff  <= req_tdata[15:0];
         s0_eidx_ff <= req_tdata[23:16];
         s0_col_ff  <= req_tdata[71:24];
      end
   end

   // stage 1: position minus zero offset, split into sign and magnitude
   assign diff   = {6'd0, s0_pos_ff} - {zero_offset_ff[20], zero_offset_ff};
   assign mag_in = sctl_pkg::MAG_W'(diff[21] ? (~diff + 22'd1) : diff);

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         s1_op_ff   <= s0_op_ff;
         s1_neg_ff  <= diff[21];
         s1_mag_ff  <= mag_in;
         s1_eidx_ff <= s0_eidx_ff;
         s1_col_ff  <= s0_col_ff;
      end
   end

   // stage 2: magnitude times gain, integer part
   assign gprod = GPROD_W'(s1_mag_ff) * GPROD_W'(index_gain_ff);

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         s2_op_ff   <= s1_op_ff;
         s2_neg_ff  <= s1_neg_ff;
         s2_prod_ff <= gprod[GPROD_W-1:sctl_pkg::GAIN_W];
         s2_eidx_ff <= s1_eidx_ff;
         s2_col_ff  <= s1_col_ff;
      end
   end

   // stage 3: quotient estimate by reciprocal, low by at most one
   assign qprod = QPROD_W'(s2_prod_ff) * QPROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         s3_op_ff   <= s2_op_ff;
         s3_neg_ff  <= s2_neg_ff;
         s3_prod_ff <= s2_prod_ff;
         s3_quot_ff <= sctl_pkg::MAG_W'(qprod >> RECIP_SHIFT);
         s3_eidx_ff <= s2_eidx_ff;
         s3_col_ff  <= s2_col_ff;
      end
   end

   // stage 4: residue below twice the table size, range flags
   assign qn         = sctl_pkg::MAG_W'(s3_quot_ff * sctl_pkg::MAG_W'(TABLE_ENTRIES));
   assign resid_full = s3_prod_ff - qn;

   always_ff @(posedge clock) begin
      if (ld[4]) begin
         s4_op_ff    <= s3_op_ff;
         s4_neg_ff   <= s3_neg_ff;
         s4_below_ff <= s3_neg_ff && (s3_prod_ff != '0);
         s4_above_ff <= !s3_neg_ff && (s3_prod_ff >= sctl_pkg::MAG_W'(TABLE_ENTRIES));
         s4_resid_ff <= RES_W'(resid_full);
         s4_idx_ff   <= IDX_W'(s3_prod_ff);
         s4_eidx_ff  <= s3_eidx_ff;
         s4_col_ff   <= s3_col_ff;
      end
   end

   // stage 5: final index per end mode
   assign res_a    = (s4_resid_ff >= N_RES) ? s4_resid_ff - N_RES : s4_resid_ff;
   assign res_b    = (s4_neg_ff && res_a != '0) ? N_RES - res_a : res_a;
   assign lo_white = (ends_mode_ff == sctl_pkg::ENDS_WHITE_BLACK) ^ flip_ends_ff;

   always_comb begin
      s5_idx_in   = s4_idx_ff;
      s5_level_in = 1'b0;
      s5_white_in = 1'b0;
      if (ends_mode_ff == sctl_pkg::ENDS_WRAP) begin
         s5_idx_in = IDX_W'(res_b);
      end else if (s4_below_ff) begin
         s5_idx_in   = '0;
         s5_level_in = (ends_mode_ff != sctl_pkg::ENDS_TABLE);
         s5_white_in = lo_white;
      end else if (s4_above_ff) begin
         s5_idx_in   = IDX_TOP;
         s5_level_in = (ends_mode_ff != sctl_pkg::ENDS_TABLE);
         s5_white_in = !lo_white;
      end
   end

   assign tbl_we = ld[5] && valid_ff[4] && (s4_op_ff == sctl_pkg::OP_WRITE) &&
                   (CMP_W'(s4_eidx_ff) < CMP_W'(TABLE_ENTRIES));

   // colour table: one write and one registered read per cycle while stage 5 loads
   always_ff @(posedge clock) begin
      if (tbl_we) table_mem[IDX_W'(s4_eidx_ff)] <= s4_col_ff;
   end

   always_ff @(posedge clock) begin
      if (ld[5]) begin
         mem_rd_ff   <= table_mem[s5_idx_in];
         s5_idx_ff   <= s5_idx_in;
         s5_level_ff <= s5_level_in;
         s5_white_ff <= s5_white_in;
      end
   end

   // output word: end level or table colour
   assign rsp_col_in = s5_level_ff ? {COL3_W{s5_white_ff}} : mem_rd_ff;

   always_ff @(posedge clock) begin
      if (ld[6]) rsp_data_ff <= {sctl_pkg::IDX_OUT_W'(s5_idx_ff), rsp_col_in};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   // reciprocal quotient is never high and at most one low
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> (qn <= s3_prod_ff) &&
                      (resid_full < sctl_pkg::MAG_W'(2 * TABLE_ENTRIES)))
      else $error("wrap residue out of range");

   // wrapped index lands inside the table
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[5] && ends_mode_ff == sctl_pkg::ENDS_WRAP) |->
         ({1'b0, s5_idx_ff} < N_RES))
      else $error("wrapped index beyond table");

   // a response word comes from the read stage or was already waiting
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $past(valid_ff[5] && ld[6]) || $past(rsp_valid_ff && !rsp_tready))
      else $error("response word without a lookup");

   // a full stalled pipe holds every stage
   assert property (@(posedge clock) disable iff (reset)
      (!req_tready && !reset) |=> $stable(valid_ff) && $stable(rsp_valid_ff))
      else $error("stage moved while stalled");
`endif

endmodule
